// File: design/bkvr_pkg.sv
package bkvr_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned KindW    = 4;
    localparam int unsigned MatchW   = 4;
    localparam int unsigned PadW     = 2;
    localparam int unsigned DateLen  = 12;

    localparam logic [ByteW-1:0] BYTE_LIST  = 8'h00;
    localparam logic [ByteW-1:0] BYTE_STR   = 8'h01;
    localparam logic [ByteW-1:0] BYTE_BOOL  = 8'h02;
    localparam logic [ByteW-1:0] BYTE_CLOSE = 8'h08;
    localparam logic [ByteW-1:0] BYTE_NUL   = 8'h00;
    localparam logic [ByteW-1:0] BYTE_ONE   = 8'h01;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_WAIT  = 3'd1,
        PH_KEY   = 3'd2,
        PH_VALUE = 3'd3,
        PH_PAD   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        FK_STRING = 2'd0,
        FK_BOOL   = 2'd1,
        FK_DATE   = 2'd2,
        FK_LIST   = 2'd3
    } t_field;

    typedef enum logic [1:0] {
        LP_WAIT  = 2'd0,
        LP_INDEX = 2'd1,
        LP_ITEM  = 2'd2
    } t_list_phase;

    typedef enum logic [KindW-1:0] {
        TK_KEY_BYTE  = 4'd0,
        TK_KEY_END   = 4'd1,
        TK_STR_BYTE  = 4'd2,
        TK_STR_END   = 4'd3,
        TK_BOOL      = 4'd4,
        TK_DATE      = 4'd5,
        TK_ITEM_BYTE = 4'd6,
        TK_ITEM_END  = 4'd7,
        TK_ENTRY_END = 4'd8
    } t_token_kind;

    typedef struct packed {
        t_phase           phase;
        t_field           field;
        t_list_phase      lphase;
        logic [PadW-1:0]  pad_count;
        logic [MatchW-1:0] match_pos;
        logic             mismatch;
    } t_state;

    typedef struct packed {
        t_token_kind      kind;
        logic [ByteW-1:0] data;
        logic             is_date;
    } t_token;

    // characters of the date key name, LastPlayTime
    function automatic logic [ByteW-1:0] date_char(input logic [MatchW-1:0] pos);
        logic [ByteW-1:0] c;
        case (pos)
            4'd0:    c = 8'h4C;
            4'd1:    c = 8'h61;
            4'd2:    c = 8'h73;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h50;
            4'd5:    c = 8'h6C;
            4'd6:    c = 8'h61;
            4'd7:    c = 8'h79;
            4'd8:    c = 8'h54;
            4'd9:    c = 8'h69;
            4'd10:   c = 8'h6D;
            4'd11:   c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/bkvr_in_if.sv
interface bkvr_in_if;
    logic                      valid;
    logic                      ready;
    logic [bkvr_pkg::ByteW-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// File: design/bkvr_out_if.sv
interface bkvr_out_if;
    logic                       valid;
    logic                       ready;
    logic [bkvr_pkg::KindW-1:0] token_kind;
    logic [bkvr_pkg::ByteW-1:0] data_byte;
    logic                       key_is_date;

    modport source (output valid, output token_kind, output data_byte, output key_is_date,
                    input ready);
    modport sink   (input valid, input token_kind, input data_byte, input key_is_date,
                    output ready);
endinterface

// File: design/bkvr_core.sv
module bkvr_core (
    input  bkvr_pkg::t_state            i_state,
    input  logic [bkvr_pkg::ByteW-1:0]  i_byte,
    output bkvr_pkg::t_state            o_state,
    output logic                        o_tok_valid,
    output bkvr_pkg::t_token            o_tok
);

    logic key_hit;
    logic is_date;

    assign key_hit = !i_state.mismatch
                     && (i_state.match_pos < bkvr_pkg::MatchW'(bkvr_pkg::DateLen))
                     && (i_byte == bkvr_pkg::date_char(i_state.match_pos));
    assign is_date = !i_state.mismatch
                     && (i_state.match_pos == bkvr_pkg::MatchW'(bkvr_pkg::DateLen));

    always_comb begin
        o_state     = i_state;
        o_tok_valid = 1'b0;
        o_tok.kind    = bkvr_pkg::TK_KEY_BYTE;
        o_tok.data    = '0;
        o_tok.is_date = 1'b0;

        case (i_state.phase)
            bkvr_pkg::PH_START: begin
                if (i_byte == bkvr_pkg::BYTE_STR) begin
                    o_state.field     = bkvr_pkg::FK_STRING;
                    o_state.phase     = bkvr_pkg::PH_KEY;
                    o_state.match_pos = '0;
                    o_state.mismatch  = 1'b0;
                end
            end
            bkvr_pkg::PH_WAIT: begin
                if (i_byte != bkvr_pkg::BYTE_CLOSE) begin
                    if (i_byte == bkvr_pkg::BYTE_STR)  o_state.field = bkvr_pkg::FK_STRING;
                    if (i_byte == bkvr_pkg::BYTE_BOOL) o_state.field = bkvr_pkg::FK_BOOL;
                    if (i_byte == bkvr_pkg::BYTE_LIST) o_state.field = bkvr_pkg::FK_LIST;
                    o_state.phase     = bkvr_pkg::PH_KEY;
                    o_state.match_pos = '0;
                    o_state.mismatch  = 1'b0;
                end
            end
            bkvr_pkg::PH_KEY: begin
                o_tok_valid = 1'b1;
                if (i_byte != bkvr_pkg::BYTE_NUL) begin
                    if (key_hit) o_state.match_pos = i_state.match_pos + 1'b1;
                    else         o_state.mismatch  = 1'b1;
                    o_tok.kind = bkvr_pkg::TK_KEY_BYTE;
                    o_tok.data = i_byte;
                end else begin
                    o_state.phase = bkvr_pkg::PH_VALUE;
                    if (is_date) o_state.field = bkvr_pkg::FK_DATE;
                    o_tok.kind    = bkvr_pkg::TK_KEY_END;
                    o_tok.is_date = is_date;
                end
            end
            bkvr_pkg::PH_VALUE: begin
                case (i_state.field)
                    bkvr_pkg::FK_STRING: begin
                        o_tok_valid = 1'b1;
                        if (i_byte != bkvr_pkg::BYTE_NUL) begin
                            o_tok.kind = bkvr_pkg::TK_STR_BYTE;
                            o_tok.data = i_byte;
                        end else begin
                            o_state.phase = bkvr_pkg::PH_WAIT;
                            o_tok.kind    = bkvr_pkg::TK_STR_END;
                        end
                    end
                    bkvr_pkg::FK_BOOL: begin
                        o_state.phase = bkvr_pkg::PH_PAD;
                        if (i_byte == bkvr_pkg::BYTE_NUL || i_byte == bkvr_pkg::BYTE_ONE) begin
                            o_tok_valid = 1'b1;
                            o_tok.kind  = bkvr_pkg::TK_BOOL;
                            o_tok.data  = i_byte;
                        end
                    end
                    bkvr_pkg::FK_DATE: begin
                        o_state.phase = bkvr_pkg::PH_PAD;
                        o_tok_valid   = 1'b1;
                        o_tok.kind    = bkvr_pkg::TK_DATE;
                    end
                    default: begin
                        case (i_state.lphase)
                            bkvr_pkg::LP_WAIT: begin
                                if (i_byte == bkvr_pkg::BYTE_CLOSE) begin
                                    // first close byte is remembered, second ends the entry
                                    if (i_state.pad_count == 2'd0) begin
                                        o_state.pad_count = 2'd1;
                                    end else if (i_state.pad_count == 2'd1) begin
                                        o_state.pad_count = 2'd0;
                                        o_state.phase     = bkvr_pkg::PH_START;
                                        o_tok_valid       = 1'b1;
                                        o_tok.kind        = bkvr_pkg::TK_ENTRY_END;
                                    end
                                end else begin
                                    o_state.lphase = bkvr_pkg::LP_INDEX;
                                end
                            end
                            bkvr_pkg::LP_INDEX: begin
                                if (i_byte == bkvr_pkg::BYTE_NUL)
                                    o_state.lphase = bkvr_pkg::LP_ITEM;
                            end
                            bkvr_pkg::LP_ITEM: begin
                                o_tok_valid = 1'b1;
                                if (i_byte != bkvr_pkg::BYTE_NUL) begin
                                    o_tok.kind = bkvr_pkg::TK_ITEM_BYTE;
                                    o_tok.data = i_byte;
                                end else begin
                                    o_state.lphase = bkvr_pkg::LP_WAIT;
                                    o_tok.kind     = bkvr_pkg::TK_ITEM_END;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                endcase
            end
            bkvr_pkg::PH_PAD: begin
                if (i_state.field == bkvr_pkg::FK_BOOL || i_state.field == bkvr_pkg::FK_DATE) begin
                    if (i_state.pad_count < 2'd2) begin
                        o_state.pad_count = i_state.pad_count + 1'b1;
                    end else begin
                        o_state.pad_count = 2'd0;
                        o_state.phase     = bkvr_pkg::PH_WAIT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: design/binary_keyvalue_record_tokenizer.sv
// channel   | dir | payload                               | transaction
// i_in      | in  | byte_in                               | one raw record byte
// o_out     | out | token_kind, data_byte, key_is_date    | one token
//
// a byte is taken into an input register, decoded combinationally by bkvr_core
// against the parse state, and its token (if any) lands in the output register
// one byte per cycle sustained while no token waits on a full output register
// the output register stalls only the bytes that make a token; bytes with no
// token drain even while a token waits
// synchronous reset puts the parser in the entry start phase with empty registers
module binary_keyvalue_record_tokenizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bkvr_in_if.sink        i_in,
    bkvr_out_if.source     o_out
);

    bkvr_pkg::t_state                r_state;
    bkvr_pkg::t_state                n_state;
    logic                            r_in_valid;
    logic [bkvr_pkg::ByteW-1:0]      r_in_byte;
    logic                            r_out_valid;
    bkvr_pkg::t_token                r_out_tok;

    logic                            tok_valid;
    bkvr_pkg::t_token                tok;
    logic                            out_free;
    logic                            advance;

    bkvr_core u_core (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_tok_valid (tok_valid),
        .o_tok       (tok)
    );

    assign out_free = !r_out_valid || o_out.ready;
    // the registered byte moves on unless its token has nowhere to go
    assign advance  = r_in_valid && (!tok_valid || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.phase       <= bkvr_pkg::PH_START;
            r_state.field       <= bkvr_pkg::FK_STRING;
            r_state.lphase      <= bkvr_pkg::LP_WAIT;
            r_state.pad_count   <= '0;
            r_state.match_pos   <= '0;
            r_state.mismatch    <= 1'b0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (advance) r_state <= n_state;
            if (advance && tok_valid) r_out_valid <= 1'b1;
            else if (o_out.ready)     r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) r_in_byte <= i_in.byte_in;
        if (advance && tok_valid)     r_out_tok <= tok;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.token_kind  = r_out_tok.kind;
    assign o_out.data_byte   = r_out_tok.data;
    assign o_out.key_is_date = r_out_tok.is_date;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import bkvr_pkg::*;

    localparam int unsigned RANDOM_PER_MODE = 140;
    localparam int unsigned HOLD_CYCLES     = 80;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;

    localparam logic [8*DateLen-1:0] DATE_KEY = "LastPlayTime";

    typedef struct packed {
        logic [ByteW-1:0] b;
        bit               typed;
        bit               present;
        t_token           tok;
    } stim_row_t;

    localparam t_token NO_TOK = '{TK_KEY_BYTE, 8'h00, 1'b0};

    // rows with typed set carry their own expectation, the rest go through the predictor
    localparam stim_row_t DIRECTED_ROWS [24] = '{
        '{8'hFF,      1'b1, 1'b0, NO_TOK},
        '{BYTE_STR,   1'b1, 1'b0, NO_TOK},
        '{8'hFF,      1'b1, 1'b1, '{TK_KEY_BYTE, 8'hFF, 1'b0}},
        '{BYTE_NUL,   1'b1, 1'b1, '{TK_KEY_END, 8'h00, 1'b0}},
        '{8'h80,      1'b0, 1'b0, NO_TOK},
        '{BYTE_NUL,   1'b1, 1'b1, '{TK_STR_END, 8'h00, 1'b0}},
        '{BYTE_CLOSE, 1'b1, 1'b0, NO_TOK},
        '{BYTE_BOOL,  1'b0, 1'b0, NO_TOK},
        '{8'h01,      1'b0, 1'b0, NO_TOK},
        '{BYTE_NUL,   1'b0, 1'b0, NO_TOK},
        '{BYTE_ONE,   1'b1, 1'b1, '{TK_BOOL, 8'h01, 1'b0}},
        '{8'hFF,      1'b1, 1'b0, NO_TOK},
        '{BYTE_CLOSE, 1'b1, 1'b0, NO_TOK},
        '{BYTE_NUL,   1'b1, 1'b0, NO_TOK},
        '{BYTE_LIST,  1'b0, 1'b0, NO_TOK},
        '{8'h4C,      1'b0, 1'b0, NO_TOK},
        '{BYTE_NUL,   1'b0, 1'b0, NO_TOK},
        '{BYTE_CLOSE, 1'b1, 1'b0, NO_TOK},
        '{8'hAA,      1'b1, 1'b0, NO_TOK},
        '{BYTE_NUL,   1'b1, 1'b0, NO_TOK},
        '{8'h7F,      1'b0, 1'b0, NO_TOK},
        '{BYTE_NUL,   1'b1, 1'b1, '{TK_ITEM_END, 8'h00, 1'b0}},
        '{BYTE_CLOSE, 1'b1, 1'b1, '{TK_ENTRY_END, 8'h00, 1'b0}},
        '{BYTE_CLOSE, 1'b1, 1'b0, NO_TOK}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    bkvr_in_if  byte_ch ();
    bkvr_out_if token_ch ();

    binary_keyvalue_record_tokenizer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (token_ch)
    );

    // typed expectation travels alongside the byte it belongs to
    bit     row_typed   = 1'b0;
    bit     row_present = 1'b0;
    t_token row_tok     = NO_TOK;

    t_token expected_tokens [$];
    int     mismatch_cnt  = 0;
    int     stall_cycles  = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_requests = 0;
    int     holds_done    = 0;

    // tokenizer state as the predictor sees it
    t_phase            cur_phase   = PH_START;
    t_field            cur_field   = FK_STRING;
    t_list_phase       cur_list    = LP_WAIT;
    logic [PadW-1:0]   pad_cnt     = '0;
    logic [MatchW-1:0] match_pos   = '0;
    logic              key_differs = 1'b0;

    // record stream generator
    logic [ByteW-1:0] record_bytes [$];
    t_field           gen_field     = FK_STRING;
    int               ignorable_cnt = 0;
    int               fed_cnt       = 0;

    function automatic logic [ByteW-1:0] date_key_char(input int unsigned pos);
        return DATE_KEY[8*(DateLen-1-pos) +: 8];
    endfunction

    function automatic t_token make_tok(input t_token_kind kind, input logic [ByteW-1:0] data,
                                        input logic is_date);
        t_token t;
        t.kind    = kind;
        t.data    = data;
        t.is_date = is_date;
        return t;
    endfunction

    function automatic void open_key();
        cur_phase   = PH_KEY;
        match_pos   = '0;
        key_differs = 1'b0;
    endfunction

    function automatic bit predict_token(input logic [ByteW-1:0] b, output t_token tok);
        bit   makes;
        logic date_hit;
        makes = 1'b0;
        tok   = NO_TOK;
        case (cur_phase)
            PH_START: begin
                if (b == BYTE_STR) begin
                    cur_field = FK_STRING;
                    open_key();
                end
            end
            PH_WAIT: begin
                if (b != BYTE_CLOSE) begin
                    if (b == BYTE_STR)  cur_field = FK_STRING;
                    if (b == BYTE_BOOL) cur_field = FK_BOOL;
                    if (b == BYTE_LIST) cur_field = FK_LIST;
                    open_key();
                end
            end
            PH_KEY: begin
                makes = 1'b1;
                if (b != BYTE_NUL) begin
                    if (!key_differs && match_pos < DateLen && b == date_key_char(match_pos))
                        match_pos = match_pos + 1'b1;
                    else
                        key_differs = 1'b1;
                    tok = make_tok(TK_KEY_BYTE, b, 1'b0);
                end else begin
                    date_hit  = !key_differs && match_pos == DateLen;
                    cur_phase = PH_VALUE;
                    if (date_hit) cur_field = FK_DATE;
                    tok = make_tok(TK_KEY_END, 8'h00, date_hit);
                end
            end
            PH_VALUE: begin
                case (cur_field)
                    FK_STRING: begin
                        makes = 1'b1;
                        if (b != BYTE_NUL) begin
                            tok = make_tok(TK_STR_BYTE, b, 1'b0);
                        end else begin
                            cur_phase = PH_WAIT;
                            tok = make_tok(TK_STR_END, 8'h00, 1'b0);
                        end
                    end
                    FK_BOOL: begin
                        cur_phase = PH_PAD;
                        if (b == BYTE_NUL || b == BYTE_ONE) begin
                            makes = 1'b1;
                            tok = make_tok(TK_BOOL, b, 1'b0);
                        end
                    end
                    FK_DATE: begin
                        cur_phase = PH_PAD;
                        makes = 1'b1;
                        tok = make_tok(TK_DATE, 8'h00, 1'b0);
                    end
                    default: begin
                        case (cur_list)
                            LP_WAIT: begin
                                if (b != BYTE_CLOSE) begin
                                    cur_list = LP_INDEX;
                                end else if (pad_cnt == 0) begin
                                    pad_cnt = PadW'(1);
                                end else if (pad_cnt == 1) begin
                                    pad_cnt   = '0;
                                    cur_phase = PH_START;
                                    makes = 1'b1;
                                    tok = make_tok(TK_ENTRY_END, 8'h00, 1'b0);
                                end
                            end
                            LP_INDEX: begin
                                if (b == BYTE_NUL) cur_list = LP_ITEM;
                            end
                            LP_ITEM: begin
                                makes = 1'b1;
                                if (b != BYTE_NUL) begin
                                    tok = make_tok(TK_ITEM_BYTE, b, 1'b0);
                                end else begin
                                    cur_list = LP_WAIT;
                                    tok = make_tok(TK_ITEM_END, 8'h00, 1'b0);
                                end
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            PH_PAD: begin
                if (cur_field == FK_BOOL || cur_field == FK_DATE) begin
                    if (pad_cnt < 2) begin
                        pad_cnt = pad_cnt + 1'b1;
                    end else begin
                        pad_cnt   = '0;
                        cur_phase = PH_WAIT;
                    end
                end
            end
            default: ;
        endcase
        return makes;
    endfunction

    function automatic void push_nonzero(input int unsigned n);
        repeat (n) record_bytes.push_back(ByteW'($urandom_range(1, 255)));
    endfunction

    // full date name, a prefix of it, an overlong one, or a plain key
    function automatic void gen_key();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            n = (pick < 40) ? DateLen : $urandom_range(1, DateLen - 1);
            for (int i = 0; i < n; i++) record_bytes.push_back(date_key_char(i));
            if (pick < 30)
                gen_field = FK_DATE;
            else if (pick < 40)
                push_nonzero(1);
        end else begin
            push_nonzero($urandom_range(1, 6));
        end
        record_bytes.push_back(BYTE_NUL);
    endfunction

    function automatic void gen_value();
        case (gen_field)
            FK_STRING: begin
                push_nonzero($urandom_range(0, 5));
                record_bytes.push_back(BYTE_NUL);
            end
            FK_BOOL: begin
                if ($urandom_range(0, 99) < 80)
                    record_bytes.push_back(ByteW'($urandom_range(0, 1)));
                else
                    record_bytes.push_back(ByteW'($urandom_range(0, 255)));
                repeat (3) record_bytes.push_back(ByteW'($urandom_range(0, 255)));
            end
            default: begin
                repeat (4) record_bytes.push_back(ByteW'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void gen_list();
        int unsigned      n;
        int unsigned      split;
        bit               early;
        logic [ByteW-1:0] b;
        n     = $urandom_range(0, 3);
        split = $urandom_range(0, n);
        early = ($urandom_range(0, 99) < 15);
        for (int k = 0; k < n; k++) begin
            if (early && k == split) record_bytes.push_back(BYTE_CLOSE);
            b = ByteW'($urandom_range(0, 255));
            if (b == BYTE_CLOSE) b = BYTE_STR;
            record_bytes.push_back(b);
            push_nonzero($urandom_range(0, 2));
            record_bytes.push_back(BYTE_NUL);
            push_nonzero($urandom_range(0, 5));
            record_bytes.push_back(BYTE_NUL);
        end
        record_bytes.push_back(BYTE_CLOSE);
        record_bytes.push_back(BYTE_CLOSE);
    endfunction

    function automatic void gen_entry();
        logic [ByteW-1:0] b;
        int unsigned      p;
        if ($urandom_range(0, 99) < 20) begin
            b = ByteW'($urandom_range(0, 255));
            if (b == BYTE_STR) b = 8'hFF;
            record_bytes.push_back(b);
            ignorable_cnt++;
        end
        record_bytes.push_back(BYTE_STR);
        gen_field = FK_STRING;
        gen_key();
        gen_value();
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 99) < 10) begin
                record_bytes.push_back(BYTE_CLOSE);
                ignorable_cnt++;
            end
            p = $urandom_range(0, 99);
            if (p < 35) begin
                record_bytes.push_back(BYTE_STR);
                gen_field = FK_STRING;
            end else if (p < 70) begin
                record_bytes.push_back(BYTE_BOOL);
                gen_field = FK_BOOL;
            end else begin
                // unknown type byte keeps the previous field kind
                b = ByteW'($urandom_range(3, 255));
                if (b == BYTE_CLOSE) b = 8'hFF;
                record_bytes.push_back(b);
            end
            gen_key();
            gen_value();
        end
        if ($urandom_range(0, 99) < 80) begin
            record_bytes.push_back(BYTE_LIST);
            gen_field = FK_LIST;
            gen_key();
            if (gen_field == FK_DATE)
                gen_value();
            else
                gen_list();
        end
        // broken record: a stray byte somewhere in the entry
        if ($urandom_range(0, 99) < 6)
            record_bytes.insert($urandom_range(0, record_bytes.size()),
                                ByteW'($urandom_range(0, 255)));
    endfunction

    task automatic report_mismatch(input string what, input logic [ByteW-1:0] got,
                                   input logic [ByteW-1:0] want);
        $display("%0t: token mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic send_byte(input logic [ByteW-1:0] b, input bit typed, input bit present,
                             input t_token tok);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        row_typed       <= typed;
        row_present     <= present;
        row_tok         <= tok;
        do @(posedge clk); while (!byte_ch.ready);
    endtask

    // prediction on each input transaction, check on each output transaction
    always @(posedge clk) begin
        t_token tok;
        t_token want;
        bit     makes;
        if (rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                makes = predict_token(byte_ch.byte_in, tok);
                if (row_typed) begin
                    makes = row_present;
                    tok   = row_tok;
                end
                if (makes) expected_tokens.push_back(tok);
            end
            if (token_ch.valid && token_ch.ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("token_kind (none expected)",
                                    ByteW'(token_ch.token_kind), 8'h00);
                end else begin
                    want = expected_tokens.pop_front();
                    if (token_ch.token_kind !== want.kind)
                        report_mismatch("token_kind", ByteW'(token_ch.token_kind),
                                        ByteW'(want.kind));
                    if (token_ch.data_byte !== want.data)
                        report_mismatch("data_byte", token_ch.data_byte, want.data);
                    if (token_ch.key_is_date !== want.is_date)
                        report_mismatch("key_is_date", ByteW'(token_ch.key_is_date),
                                        ByteW'(want.is_date));
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        token_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                token_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                token_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        byte_ch.valid   <= 1'b0;
        byte_ch.byte_in <= '0;
        send_idle_pct = 10;
        recv_idle_pct = 46;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].present,
                      DIRECTED_ROWS[i].tok);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 46 : 0;
            recv_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 10 : 0;
            if (mode > 0) begin
                // let the pipeline run dry before the next idling pattern
                byte_ch.valid <= 1'b0;
                while (expected_tokens.size() != 0) @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            if (mode == 2) hold_requests++;
            while (fed_cnt - ignorable_cnt < (mode + 1) * RANDOM_PER_MODE) begin
                if (record_bytes.size() == 0) gen_entry();
                send_byte(record_bytes.pop_front(), 1'b0, 1'b0, NO_TOK);
                fed_cnt++;
            end
        end

        byte_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
design/bkvr_pkg.sv
design/bkvr_in_if.sv
design/bkvr_out_if.sv
design/bkvr_core.sv
design/binary_keyvalue_record_tokenizer.sv
tb/tb_top.sv
